// ----- src/pidv_pkg.sv -----
// Shared types, constants and the control program of the PID velocity controller.
`default_nettype none

package pidv_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Partial product chunk widths of the shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;

    // Register file
    localparam int REG_IDX_W = 3;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_KP   = 3'd0;
    localparam reg_idx_t REG_KI   = 3'd1;
    localparam reg_idx_t REG_KD   = 3'd2;
    localparam reg_idx_t REG_STEP = 3'd3;
    localparam reg_idx_t REG_INV  = 3'd4;
    localparam reg_idx_t REG_BIAS = 3'd5;

    localparam logic [63:0] RST_KP   = 64'd1311;
    localparam logic [63:0] RST_KI   = 64'd328;
    localparam logic [63:0] RST_KD   = 64'd13107;
    localparam logic [63:0] RST_STEP = 64'd6554;
    localparam logic [63:0] RST_INV  = 64'd655360;
    localparam logic [63:0] RST_BIAS = 64'd23658;

    // Sequencer
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD_E,
        OP_DIFF,
        OP_ESUM,
        OP_SUM_SET,
        OP_DER,
        OP_SUM_ADD,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        A_E,
        A_DIFF,
        A_KP,
        A_KI,
        A_KD
    } a_sel_t;

    typedef enum logic [2:0] {
        B_STEP,
        B_INV,
        B_E,
        B_ESUM,
        B_DER
    } b_sel_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_IN,
        C_MUL,
        C_OUT
    } cond_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_ACC,
        MUL_FIN
    } mul_state_t;

    typedef struct packed {
        op_t    op;
        a_sel_t a_sel;
        b_sel_t b_sel;
        cond_t  cond;
        logic   mstart;
        step_t  target;
    } ucode_t;

    typedef struct packed {
        op_t    op;
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   mstart;
        logic   exec;
    } seq_ctrl_t;

    typedef struct packed {
        logic mul_done;
        logic mul_busy;
        logic out_free;
    } dp_status_t;

    // Control program: a wait step executes its op, and starts the next
    // product if it has one, in the cycle the previous product is done.
    function automatic ucode_t ucode(input step_t step);
        ucode_t w;
        case (step)
            3'd0:    w = '{OP_LOAD_E,  A_E,    B_E,    C_IN,   1'b0, 3'd1};
            3'd1:    w = '{OP_DIFF,    A_E,    B_STEP, C_NEXT, 1'b1, 3'd2};
            3'd2:    w = '{OP_ESUM,    A_KP,   B_E,    C_MUL,  1'b1, 3'd3};
            3'd3:    w = '{OP_SUM_SET, A_DIFF, B_INV,  C_MUL,  1'b1, 3'd4};
            3'd4:    w = '{OP_DER,     A_KI,   B_ESUM, C_MUL,  1'b1, 3'd5};
            3'd5:    w = '{OP_SUM_ADD, A_KD,   B_DER,  C_MUL,  1'b1, 3'd6};
            3'd6:    w = '{OP_SUM_ADD, A_E,    B_E,    C_MUL,  1'b0, 3'd7};
            3'd7:    w = '{OP_OUT,     A_E,    B_E,    C_OUT,  1'b0, 3'd0};
            default: w = '{OP_NOP,     A_E,    B_E,    C_NEXT, 1'b0, 3'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/pidv_cfg.sv -----
// APB register file holding gains, period, inverse period and bias.
`default_nettype none

module pidv_cfg #(
    parameter int DATA_WIDTH = pidv_pkg::DATA_WIDTH_DEF,
    parameter int PDATA_W    = 32,
    parameter int PADDR_W    = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output logic [DATA_WIDTH-1:0] kp,
    output logic [DATA_WIDTH-1:0] ki,
    output logic [DATA_WIDTH-1:0] kd,
    output logic [DATA_WIDTH-2:0] step_time,
    output logic [DATA_WIDTH-2:0] inv_step_time,
    output logic [DATA_WIDTH-1:0] hover_bias
);
    import pidv_pkg::*;

    logic [DATA_WIDTH-1:0] kp_reg;
    logic [DATA_WIDTH-1:0] ki_reg;
    logic [DATA_WIDTH-1:0] kd_reg;
    logic [DATA_WIDTH-2:0] step_reg;
    logic [DATA_WIDTH-2:0] inv_reg;
    logic [DATA_WIDTH-1:0] bias_reg;
    reg_idx_t              idx;
    logic                  wr;

    assign idx    = paddr[PADDR_W-1 -: REG_IDX_W];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= RST_KP[DATA_WIDTH-1:0];
            ki_reg   <= RST_KI[DATA_WIDTH-1:0];
            kd_reg   <= RST_KD[DATA_WIDTH-1:0];
            step_reg <= RST_STEP[DATA_WIDTH-2:0];
            inv_reg  <= RST_INV[DATA_WIDTH-2:0];
            bias_reg <= RST_BIAS[DATA_WIDTH-1:0];
        end
        else if (wr)
        begin
            case (idx)
                REG_KP:   kp_reg   <= pwdata[DATA_WIDTH-1:0];
                REG_KI:   ki_reg   <= pwdata[DATA_WIDTH-1:0];
                REG_KD:   kd_reg   <= pwdata[DATA_WIDTH-1:0];
                REG_STEP: step_reg <= pwdata[DATA_WIDTH-2:0];
                REG_INV:  inv_reg  <= pwdata[DATA_WIDTH-2:0];
                REG_BIAS: bias_reg <= pwdata[DATA_WIDTH-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KP:   prdata = PDATA_W'(kp_reg);
            REG_KI:   prdata = PDATA_W'(ki_reg);
            REG_KD:   prdata = PDATA_W'(kd_reg);
            REG_STEP: prdata = PDATA_W'(step_reg);
            REG_INV:  prdata = PDATA_W'(inv_reg);
            REG_BIAS: prdata = PDATA_W'(bias_reg);
            default:  prdata = '0;
        endcase
    end

    assign kp            = kp_reg;
    assign ki            = ki_reg;
    assign kd            = kd_reg;
    assign step_time     = step_reg;
    assign inv_step_time = inv_reg;
    assign hover_bias    = bias_reg;

endmodule

`default_nettype wire

// ----- src/pidv_mul.sv -----
// Shared fixed-point multiplier: chunked partial products, floor shift, saturation.
`default_nettype none

module pidv_mul #(
    parameter int DATA_WIDTH = pidv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidv_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH:0]   op_a,
    input  logic signed [DATA_WIDTH-1:0] op_b,
    output logic                         busy,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result
);
    import pidv_pkg::*;

    localparam int AW   = DATA_WIDTH + 1;
    localparam int BW   = DATA_WIDTH;
    localparam int NA   = (AW + MUL_A_W - 1) / MUL_A_W;
    localparam int NB   = (BW + MUL_B_W - 1) / MUL_B_W;
    localparam int APW  = NA * MUL_A_W;
    localparam int BPW  = NB * MUL_B_W;
    localparam int PW   = APW + BPW;
    localparam int IA_W = (NA > 1) ? $clog2(NA) : 1;
    localparam int IB_W = (NB > 1) ? $clog2(NB) : 1;
    localparam int QW   = PW - FRAC_BITS + 1;
    localparam logic [QW-1:0] LIM = QW'(1) << (DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] SMAX = ~SMIN;

    mul_state_t                    state_reg, state_next;
    logic [APW-1:0]                a_mag_reg;
    logic [BPW-1:0]                b_mag_reg;
    logic                          neg_reg;
    logic [PW-1:0]                 acc_reg;
    logic [IA_W-1:0]               ia_reg;
    logic [IB_W-1:0]               ib_reg;
    logic                          done_reg;
    logic [DATA_WIDTH-1:0]         result_reg;

    logic [AW-1:0]                 a_abs;
    logic [BW-1:0]                 b_abs;
    logic [MUL_A_W-1:0]            a_chunk;
    logic [MUL_B_W-1:0]            b_chunk;
    logic [MUL_A_W+MUL_B_W-1:0]    prod;
    logic [PW-1:0]                 pp_shifted;
    logic                          last_pp;
    logic                          acc_en;
    logic                          fin_en;
    logic [QW-1:0]                 q;
    logic [QW-1:0]                 qn;
    logic                          rem;
    logic [DATA_WIDTH-1:0]         fin_val;

    assign a_abs = op_a[DATA_WIDTH]   ? (~op_a + 1'b1) : op_a;
    assign b_abs = op_b[DATA_WIDTH-1] ? (~op_b + 1'b1) : op_b;

    assign a_chunk    = a_mag_reg[ia_reg*MUL_A_W +: MUL_A_W];
    assign b_chunk    = b_mag_reg[ib_reg*MUL_B_W +: MUL_B_W];
    assign prod       = a_chunk * b_chunk;
    assign pp_shifted = PW'(prod) << (ia_reg*MUL_A_W + ib_reg*MUL_B_W);
    assign last_pp    = (ia_reg == IA_W'(NA - 1)) && (ib_reg == IB_W'(NB - 1));

    // Floor toward minus infinity: a negative product with a fraction rounds away from zero
    always_comb
    begin
        q   = {1'b0, acc_reg[PW-1:FRAC_BITS]};
        rem = |acc_reg[FRAC_BITS-1:0];
        qn  = q + QW'(rem);
        if (neg_reg)
        begin
            fin_val = (qn >= LIM) ? SMIN : (~qn[DATA_WIDTH-1:0] + 1'b1);
        end
        else
        begin
            fin_val = (q > LIM - 1'b1) ? SMAX : q[DATA_WIDTH-1:0];
        end
    end

    always_comb
    begin
        case (state_reg)
            MUL_IDLE: state_next = start ? MUL_ACC : MUL_IDLE;
            MUL_ACC:  state_next = last_pp ? MUL_FIN : MUL_ACC;
            MUL_FIN:  state_next = MUL_IDLE;
            default:  state_next = MUL_IDLE;
        endcase
    end

    always_comb
    begin
        acc_en = 1'b0;
        fin_en = 1'b0;
        busy   = 1'b1;
        case (state_reg)
            MUL_IDLE: busy   = 1'b0;
            MUL_ACC:  acc_en = 1'b1;
            MUL_FIN:  fin_en = 1'b1;
            default:  busy   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
            ia_reg    <= '0;
            ib_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin_en;
            if (acc_en)
            begin
                if (last_pp)
                begin
                    ia_reg <= '0;
                    ib_reg <= '0;
                end
                else if (ib_reg == IB_W'(NB - 1))
                begin
                    ib_reg <= '0;
                    ia_reg <= ia_reg + 1'b1;
                end
                else
                begin
                    ib_reg <= ib_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            a_mag_reg <= APW'(a_abs);
            b_mag_reg <= BPW'(b_abs);
            neg_reg   <= op_a[DATA_WIDTH] ^ op_b[DATA_WIDTH-1];
            acc_reg   <= '0;
        end
        else if (acc_en)
        begin
            acc_reg <= acc_reg + pp_shifted;
        end
        if (fin_en)
        begin
            result_reg <= fin_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("multiplier started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg && state_reg != MUL_FIN)
        else $error("multiplier done held for more than one cycle");

endmodule

`default_nettype wire

// ----- src/pidv_dp.sv -----
// Datapath: error, integral, PID terms, running sum and the output register.
`default_nettype none

module pidv_dp #(
    parameter int DATA_WIDTH = pidv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidv_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidv_pkg::seq_ctrl_t           ctrl,
    input  logic signed [DATA_WIDTH-1:0]  target_speed,
    input  logic signed [DATA_WIDTH-1:0]  measured_speed,
    input  logic [DATA_WIDTH-1:0]         kp,
    input  logic [DATA_WIDTH-1:0]         ki,
    input  logic [DATA_WIDTH-1:0]         kd,
    input  logic [DATA_WIDTH-2:0]         step_time,
    input  logic [DATA_WIDTH-2:0]         inv_step_time,
    input  logic [DATA_WIDTH-1:0]         hover_bias,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [DATA_WIDTH-1:0]  drive_command,
    output pidv_pkg::dp_status_t          status
);
    import pidv_pkg::*;

    localparam int AW = DATA_WIDTH + 1;
    localparam int SW = DATA_WIDTH + 2;
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] SMAX = ~SMIN;

    logic signed [DATA_WIDTH-1:0] e_reg;
    logic signed [AW-1:0]         diff_reg;
    logic signed [DATA_WIDTH-1:0] esum_reg;
    logic signed [DATA_WIDTH-1:0] last_reg;
    logic signed [DATA_WIDTH-1:0] der_reg;
    logic signed [SW-1:0]         sum_reg;
    logic signed [SW-1:0]         sum_next;
    logic signed [DATA_WIDTH-1:0] out_data_reg;
    logic                         out_valid_reg;

    logic signed [AW-1:0]         e_raw;
    logic signed [DATA_WIDTH-1:0] e_sat;
    logic signed [AW-1:0]         esum_raw;
    logic signed [DATA_WIDTH-1:0] esum_sat;
    logic signed [DATA_WIDTH-1:0] sum_sat;
    logic [2:0]                   sum_top;
    logic signed [AW-1:0]         mul_a;
    logic signed [DATA_WIDTH-1:0] mul_b;
    logic signed [DATA_WIDTH-1:0] mul_res;
    logic                         mul_busy;
    logic                         mul_done;
    logic                         load_out;

    pidv_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.mstart),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res)
    );

    always_comb
    begin
        case (ctrl.a_sel)
            A_E:     mul_a = AW'(e_reg);
            A_DIFF:  mul_a = diff_reg;
            A_KP:    mul_a = AW'($signed(kp));
            A_KI:    mul_a = AW'($signed(ki));
            A_KD:    mul_a = AW'($signed(kd));
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.b_sel)
            B_STEP:  mul_b = $signed({1'b0, step_time});
            B_INV:   mul_b = $signed({1'b0, inv_step_time});
            B_E:     mul_b = e_reg;
            B_ESUM:  mul_b = esum_reg;
            B_DER:   mul_b = der_reg;
            default: mul_b = '0;
        endcase
    end

    // Saturating adders: clamp whenever the guard bits disagree with the sign
    always_comb
    begin
        e_raw = AW'(target_speed) - AW'(measured_speed);
        if (e_raw[AW-1] != e_raw[AW-2])
        begin
            e_sat = e_raw[AW-1] ? SMIN : SMAX;
        end
        else
        begin
            e_sat = e_raw[DATA_WIDTH-1:0];
        end

        esum_raw = AW'(esum_reg) + AW'(mul_res);
        if (esum_raw[AW-1] != esum_raw[AW-2])
        begin
            esum_sat = esum_raw[AW-1] ? SMIN : SMAX;
        end
        else
        begin
            esum_sat = esum_raw[DATA_WIDTH-1:0];
        end

        sum_top = sum_reg[SW-1:DATA_WIDTH-1];
        if (!((&sum_top) || !(|sum_top)))
        begin
            sum_sat = sum_reg[SW-1] ? SMIN : SMAX;
        end
        else
        begin
            sum_sat = sum_reg[DATA_WIDTH-1:0];
        end

        if (ctrl.op == OP_SUM_SET)
        begin
            sum_next = SW'($signed(hover_bias)) + SW'(mul_res);
        end
        else
        begin
            sum_next = sum_reg + SW'(mul_res);
        end
    end

    assign load_out = ctrl.exec && (ctrl.op == OP_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.exec && ctrl.op == OP_ESUM)
            begin
                esum_reg <= esum_sat;
            end
            if (ctrl.exec && ctrl.op == OP_DIFF)
            begin
                last_reg <= e_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            case (ctrl.op)
                OP_LOAD_E:  e_reg        <= e_sat;
                OP_DIFF:    diff_reg     <= AW'(e_reg) - AW'(last_reg);
                OP_SUM_SET: sum_reg      <= sum_next;
                OP_SUM_ADD: sum_reg      <= sum_next;
                OP_DER:     der_reg      <= mul_res;
                OP_OUT:     out_data_reg <= sum_sat;
                default:    ;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_command   = out_data_reg;
    assign status.mul_done = mul_done;
    assign status.mul_busy = mul_busy;
    assign status.out_free = !out_valid_reg || out_ready;

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(load_out))
        else $error("output became valid without an output step");

endmodule

`default_nettype wire

// ----- src/pidv_seq.sv -----
// Microcode sequencer: step counter, program ROM and wait conditions.
`default_nettype none

module pidv_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pidv_pkg::dp_status_t status,
    output pidv_pkg::seq_ctrl_t  ctrl
);
    import pidv_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t uc;
    logic   cond_ok;

    assign uc = ucode(step_reg);

    always_comb
    begin
        case (uc.cond)
            C_NEXT:  cond_ok = 1'b1;
            C_IN:    cond_ok = in_valid;
            C_MUL:   cond_ok = status.mul_done;
            C_OUT:   cond_ok = status.out_free;
            default: cond_ok = 1'b0;
        endcase
    end

    // Hold on the current step until its condition is met, then jump
    assign step_next   = cond_ok ? uc.target : step_reg;
    assign in_ready    = (uc.cond == C_IN);
    assign ctrl.op     = uc.op;
    assign ctrl.a_sel  = uc.a_sel;
    assign ctrl.b_sel  = uc.b_sel;
    assign ctrl.exec   = cond_ok;
    assign ctrl.mstart = uc.mstart && cond_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in progress");

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mstart |-> !status.mul_busy)
        else $error("product issued to a busy multiplier");

endmodule

`default_nettype wire

// ----- src/pid_velocity_controller_core.sv -----
// Top level of the PID velocity controller with feedforward bias.
//
// Usage: each control tick, present target_speed (s_tdata low field) and
// measured_speed (next field) on the slave stream; an item transfers when
// s_tvalid and s_tready are both high. One drive_command comes back on the
// master stream per item, in order.
// Gains, period, inverse period and bias sit in the APB registers at byte
// address 4*index (8*index when DATA_WIDTH exceeds 32); write them only
// while no item is in flight.
// Flow: a microcoded sequencer runs five products through one shared
// multiplier, each accumulating N partial products (N = 1 at DATA_WIDTH =
// 32). m_tvalid is set by the register loaded in the output step, and a new
// item is taken only after the previous item's output step has run.
// Stall: the result waits in the output register; the next item is still
// accepted and computed, and only its final output step holds until the
// register is free.
// Reset: registers return to their defaults, integral and previous error
// clear to zero, no result is pending.
`default_nettype none

module pid_velocity_controller_core #(
    parameter int FRAC_BITS  = pidv_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = pidv_pkg::DATA_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // s_tdata: target_speed, measured_speed
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
    // m_tdata: drive_command
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pidv_pkg::REG_IDX_W+(DATA_WIDTH>32 ? 3 : 2)-1:0] paddr,
    input  logic [(DATA_WIDTH>32 ? 64 : 32)-1:0]    pwdata,
    output logic [(DATA_WIDTH>32 ? 64 : 32)-1:0]    prdata,
    output logic                                    pready
);
    import pidv_pkg::*;

    localparam int OUT_W   = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int PDATA_W = (DATA_WIDTH > 32) ? 64 : 32;
    localparam int PADDR_W = REG_IDX_W + ((DATA_WIDTH > 32) ? 3 : 2);

    logic [DATA_WIDTH-1:0]        kp;
    logic [DATA_WIDTH-1:0]        ki;
    logic [DATA_WIDTH-1:0]        kd;
    logic [DATA_WIDTH-2:0]        step_time;
    logic [DATA_WIDTH-2:0]        inv_step_time;
    logic [DATA_WIDTH-1:0]        hover_bias;
    logic signed [DATA_WIDTH-1:0] target_speed;
    logic signed [DATA_WIDTH-1:0] measured_speed;
    logic signed [DATA_WIDTH-1:0] drive_command;
    seq_ctrl_t                    ctrl;
    dp_status_t                   status;

    assign target_speed   = $signed(s_tdata[DATA_WIDTH-1:0]);
    assign measured_speed = $signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
    assign m_tdata        = OUT_W'($unsigned(drive_command));

    pidv_cfg #(
        .DATA_WIDTH (DATA_WIDTH),
        .PDATA_W    (PDATA_W),
        .PADDR_W    (PADDR_W)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .kp            (kp),
        .ki            (ki),
        .kd            (kd),
        .step_time     (step_time),
        .inv_step_time (inv_step_time),
        .hover_bias    (hover_bias)
    );

    pidv_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    pidv_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .kp             (kp),
        .ki             (ki),
        .kd             (kd),
        .step_time      (step_time),
        .inv_step_time  (inv_step_time),
        .hover_bias     (hover_bias),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .drive_command  (drive_command),
        .status         (status)
    );

endmodule

`default_nettype wire
